[rtl/core/ica_pkg.sv]
package ica_pkg;

	localparam int NUM_CARS    = 6;
	localparam int COORD_WIDTH = 16;
	localparam int MARGIN_W    = 14;
	localparam int OWN_W       = 3;
	localparam int CAR_IDX_W   = $clog2(NUM_CARS);
	// widened edges: coordinate plus margin, with room for sign and carry
	localparam int EDGE_W      = ((COORD_WIDTH > MARGIN_W) ? COORD_WIDTH : MARGIN_W) + 2;
	localparam int CMD_W       = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = COORD_WIDTH;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_CAR    = 3'd5;

	localparam logic [OWN_W-1:0] OWN_CAR_RESET = 3'd1;

	// drive commands
	localparam logic [CMD_W-1:0] CMD_IGNORE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STOP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd2;

	// phase codes as reported
	localparam logic [CMD_W-1:0] PHASE_IDLE  = 2'd0;
	localparam logic [CMD_W-1:0] PHASE_WAIT  = 2'd1;
	localparam logic [CMD_W-1:0] PHASE_CROSS = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t              left;
		coord_t              right;
		coord_t              top;
		coord_t              bottom;
		logic [MARGIN_W-1:0] margin;
	} box_cfg_t;

	typedef struct packed {
		logic core_in;
		logic wide_in;
	} lane_flags_t;

	typedef struct packed {
		coord_t car1_x;
		coord_t car1_y;
		coord_t car2_x;
		coord_t car2_y;
		coord_t car3_x;
		coord_t car3_y;
		coord_t car4_x;
		coord_t car4_y;
		coord_t car5_x;
		coord_t car5_y;
		coord_t car6_x;
		coord_t car6_y;
	} in_item_t;

	typedef struct packed {
		logic [CMD_W-1:0] drive_command;
		logic [CMD_W-1:0] phase_now;
	} out_item_t;

endpackage

[rtl/core/ica_lane.sv]
module ica_lane
	import ica_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  box_cfg_t    box,
	input  coord_t      x,
	input  coord_t      y,
	output lane_flags_t flags_s1
);

	logic signed [EDGE_W-1:0] xe, ye, le, re, te, be, me;
	logic signed [EDGE_W-1:0] wl, wr, wt, wb;
	lane_flags_t              flags;

	always_comb begin
		xe = EDGE_W'(x);
		ye = EDGE_W'(y);
		le = EDGE_W'(box.left);
		re = EDGE_W'(box.right);
		te = EDGE_W'(box.top);
		be = EDGE_W'(box.bottom);
		me = $signed({{(EDGE_W-MARGIN_W){1'b0}}, box.margin});
		wl = le - me;
		wr = re + me;
		wb = be - me;
		wt = te + me;
		flags.core_in = (le < xe) && (xe < re) && (be < ye) && (ye < te);
		flags.wide_in = (wl < xe) && (xe < wr) && (wb < ye) && (ye < wt);
	end

	// hold the flags of the item in stage one
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1 <= flags;
		end
	end

endmodule

[rtl/core/ica_fsm.sv]
module ica_fsm
	import ica_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  lane_flags_t [NUM_CARS-1:0] flags_s1,
	input  logic [OWN_W-1:0]       own_car,
	input  logic                   out_stall,
	output logic                   take,
	output logic                   out_valid,
	output out_item_t              out_item
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WAIT  = 3'b010,
		ST_CROSS = 3'b100
	} phase_t;

	phase_t                 phase_q, phase_next;
	logic [CMD_W-1:0]       cmd, code;
	logic [CAR_IDX_W-1:0]   me;
	logic                   blocked, own_wide, can_load;
	out_item_t              out_q;
	logic                   out_valid_q;

	// clamp the own car number onto the cars present
	always_comb begin
		if (own_car == '0) begin
			me = '0;
		end else if (own_car > OWN_W'(NUM_CARS)) begin
			me = CAR_IDX_W'(NUM_CARS - 1);
		end else begin
			me = CAR_IDX_W'(own_car - OWN_W'(1));
		end
	end

	// merge the lane findings
	always_comb begin
		blocked = 1'b0;
		for (int i = 0; i < NUM_CARS; i++) begin
			if ((CAR_IDX_W'(i) != me) && flags_s1[i].core_in) begin
				blocked = 1'b1;
			end
			if ((CAR_IDX_W'(i) < me) && flags_s1[i].wide_in) begin
				blocked = 1'b1;
			end
		end
		own_wide = flags_s1[me].wide_in;
	end

	always_comb begin
		unique case (phase_q)
			ST_WAIT: begin
				cmd        = blocked ? CMD_STOP : CMD_FORWARD;
				phase_next = blocked ? ST_WAIT : ST_CROSS;
			end
			ST_CROSS: begin
				cmd        = CMD_IGNORE;
				phase_next = own_wide ? ST_CROSS : ST_IDLE;
			end
			default: begin
				cmd        = own_wide ? CMD_STOP : CMD_IGNORE;
				phase_next = own_wide ? ST_WAIT : ST_IDLE;
			end
		endcase
		unique case (phase_next)
			ST_WAIT:  code = PHASE_WAIT;
			ST_CROSS: code = PHASE_CROSS;
			default:  code = PHASE_IDLE;
		endcase
	end

	assign can_load = !out_valid_q || !out_stall;
	assign take     = valid_s1 && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_next;
			end
			if (can_load) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.drive_command <= cmd;
			out_q.phase_now     <= code;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[rtl/core/intersection_crossing_arbiter.sv]
// A transferred item's lane flags are registered in stage one, its result in the output register.
// Throughput: one item per cycle while out_stall does not hold the output; six position lanes
// work in parallel and the phase machine resolves each item as it leaves stage one.
// Reset (arst_n low, asynchronous): phase idle, both pipeline stages empty, box edges and
// safety margin zero, own car 1.
module intersection_crossing_arbiter
	import ica_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item
);

	box_cfg_t                   box_q;
	logic [OWN_W-1:0]           own_car_q;
	logic                       valid_s1;
	logic                       take;
	logic                       in_xfer;
	coord_t [NUM_CARS-1:0]      car_x, car_y;
	lane_flags_t [NUM_CARS-1:0] flags_s1;

	// Configuration registers: a write to an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q     <= '0;
			own_car_q <= OWN_CAR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_LEFT:   box_q.left   <= coord_t'(cfg_data);
				REG_BOX_RIGHT:  box_q.right  <= coord_t'(cfg_data);
				REG_BOX_TOP:    box_q.top    <= coord_t'(cfg_data);
				REG_BOX_BOTTOM: box_q.bottom <= coord_t'(cfg_data);
				REG_MARGIN:     box_q.margin <= cfg_data[MARGIN_W-1:0];
				REG_OWN_CAR:    own_car_q    <= cfg_data[OWN_W-1:0];
				default: ;
			endcase
		end
	end

	// Spread the snapshot over the lanes, car 1 on lane 0.
	assign car_x[0] = in_item.car1_x;
	assign car_y[0] = in_item.car1_y;
	assign car_x[1] = in_item.car2_x;
	assign car_y[1] = in_item.car2_y;
	assign car_x[2] = in_item.car3_x;
	assign car_y[2] = in_item.car3_y;
	assign car_x[3] = in_item.car4_x;
	assign car_y[3] = in_item.car4_y;
	assign car_x[4] = in_item.car5_x;
	assign car_y[4] = in_item.car5_y;
	assign car_x[5] = in_item.car6_x;
	assign car_y[5] = in_item.car6_y;

	// Stage one holds its item only while the phase stage cannot take it.
	assign in_stall = valid_s1 && !take;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// One lane per car: core and widened box tests, registered.
	for (genvar g = 0; g < NUM_CARS; g++) begin : g_lane
		ica_lane u_lane (
			.clk      (clk),
			.en       (in_xfer),
			.box      (box_q),
			.x        (car_x[g]),
			.y        (car_y[g]),
			.flags_s1 (flags_s1[g])
		);
	end

	// Merge the lane flags, advance the phase and present the result; the output
	// register lets the next item move up while a result waits for its transfer.
	ica_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.flags_s1  (flags_s1),
		.own_car   (own_car_q),
		.out_stall (out_stall),
		.take      (take),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

[tb/tb_intersection_crossing_arbiter.sv]
module tb_intersection_crossing_arbiter
	import ica_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;

	intersection_crossing_arbiter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// Shadow copy of the block's registers and phase, updated on the same edges as the block
	coord_t              box_l, box_r, box_t, box_b;
	logic [MARGIN_W-1:0] box_margin;
	logic [OWN_W-1:0]    own_sel;
	logic [CMD_W-1:0]    phase_track;

	// Scene generator's view of the current intersection (plain ints, own car already clamped)
	int gen_l, gen_r, gen_t, gen_b, gen_m, gen_me;

	in_item_t  scene_queue[$];   // snapshots waiting to be offered
	out_item_t moves_due[$];     // predicted decisions, oldest first
	out_item_t move_due;

	int  scenes_queued = 0;
	int  scenes_taken = 0;
	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	int  holdoff_left = 0;
	logic in_taken = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Position of car k (1-based); car 1 x sits in the top bits of the packed item
	function automatic coord_t car_pos(in_item_t s, int k, int is_y);
		return s[(2 * (NUM_CARS - k) + 1 - is_y) * COORD_WIDTH +: COORD_WIDTH];
	endfunction

	function automatic in_item_t put_car(in_item_t s, int k, int x, int y);
		s[(2 * (NUM_CARS - k) + 1) * COORD_WIDTH +: COORD_WIDTH] = coord_t'(x);
		s[(2 * (NUM_CARS - k)) * COORD_WIDTH +: COORD_WIDTH] = coord_t'(y);
		return s;
	endfunction

	// Strict test against the box pushed out by widen on every side; ints never wrap here
	function automatic bit in_zone(coord_t x, coord_t y, int widen);
		return (int'(box_l) - widen < int'(x)) && (int'(x) < int'(box_r) + widen) &&
			(int'(box_b) - widen < int'(y)) && (int'(y) < int'(box_t) + widen);
	endfunction

	function automatic out_item_t crossing_decision(in_item_t s, logic [CMD_W-1:0] ph);
		out_item_t r;
		int        me;
		int        m;
		bit        blocked;
		bit        own_near;
		m = int'(box_margin);
		// clamp out-of-range car numbers onto the first or last car
		me = (own_sel == 0) ? 1 : (own_sel > NUM_CARS) ? NUM_CARS : int'(own_sel);
		own_near = in_zone(car_pos(s, me, 0), car_pos(s, me, 1), m);
		blocked = 1'b0;
		if (ph == PHASE_WAIT) begin
			for (int k = 1; k <= NUM_CARS; k++) begin
				if (k != me && in_zone(car_pos(s, k, 0), car_pos(s, k, 1), 0))
					blocked = 1'b1;
				if (k < me && in_zone(car_pos(s, k, 0), car_pos(s, k, 1), m))
					blocked = 1'b1;
			end
			r.drive_command = blocked ? CMD_STOP : CMD_FORWARD;
			r.phase_now     = blocked ? PHASE_WAIT : PHASE_CROSS;
		end else if (ph == PHASE_CROSS) begin
			r.drive_command = CMD_IGNORE;
			r.phase_now     = own_near ? PHASE_CROSS : PHASE_IDLE;
		end else begin
			// idle, and the unused code, which the block treats as idle
			r.drive_command = own_near ? CMD_STOP : CMD_IGNORE;
			r.phase_now     = own_near ? PHASE_WAIT : PHASE_IDLE;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Pick one coordinate along an axis spanning lo..hi with margin m; near keeps it in the
	// widened band (interior, exact edges, the widened edge itself, just inside it, margin ring)
	function automatic int pick_coord(int lo, int hi, int m, bit near);
		int v;
		bit side;
		side = $urandom_range(1);
		if (near) begin
			case ($urandom_range(5))
				0, 1: v = (hi - lo >= 2) ? lo + 1 + int'($urandom_range(hi - lo - 2)) : lo;
				2: v = side ? hi : lo;
				3: v = side ? hi + m : lo - m;
				4: v = side ? hi + m - 1 : lo - m + 1;
				default: v = side ? hi + int'($urandom_range(m)) : lo - int'($urandom_range(m));
			endcase
		end else if ($urandom_range(1)) begin
			v = side ? hi + m + 1 + int'($urandom_range(300)) : lo - m - 1 - int'($urandom_range(300));
		end else begin
			v = int'(coord_t'($urandom));
		end
		if (v < -32768 || v > 32767)
			v = int'(coord_t'($urandom));
		return v;
	endfunction

	// Mostly well-formed traffic around the box: the own car usually approaches, the others
	// crowd the box to a level drawn per snapshot; one snapshot in ten is pure noise
	function automatic in_item_t random_scene();
		in_item_t s;
		int       busy;
		bit       near;
		bit       x_out;
		s = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		if ($urandom_range(9) == 0)
			return s;
		busy = $urandom_range(3);
		for (int k = 1; k <= NUM_CARS; k++) begin
			near = (k == gen_me) ? ($urandom_range(3) != 0) : ($urandom_range(3) < busy);
			x_out = $urandom_range(1);
			s = put_car(s, k,
				pick_coord(gen_l, gen_r, gen_m, near || !x_out),
				pick_coord(gen_b, gen_t, gen_m, near || x_out));
		end
		return s;
	endfunction

	// Program all six registers on consecutive falling edges; upper data bits are junk
	// for the narrow ones so that the block's masking is exercised
	task automatic set_crossing(input int l, input int r, input int t, input int b,
		input int m, input int own);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_BOX_LEFT;
		cfg_data  <= CFG_DATA_W'(l);
		@(negedge clk);
		cfg_index <= REG_BOX_RIGHT;
		cfg_data  <= CFG_DATA_W'(r);
		@(negedge clk);
		cfg_index <= REG_BOX_TOP;
		cfg_data  <= CFG_DATA_W'(t);
		@(negedge clk);
		cfg_index <= REG_BOX_BOTTOM;
		cfg_data  <= CFG_DATA_W'(b);
		@(negedge clk);
		cfg_index <= REG_MARGIN;
		cfg_data  <= {2'($urandom), 14'(m)};
		@(negedge clk);
		cfg_index <= REG_OWN_CAR;
		cfg_data  <= {13'($urandom), 3'(own)};
		@(negedge clk);
		cfg_we <= 1'b0;
		gen_l  = l;
		gen_r  = r;
		gen_t  = t;
		gen_b  = b;
		gen_m  = m;
		gen_me = (own == 0) ? 1 : (own > NUM_CARS) ? NUM_CARS : own;
	endtask

	// Set the pacing on a rising edge so that the driver and receiver see it cleanly
	task automatic set_pace(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	task automatic queue_scene(input in_item_t s);
		scene_queue.push_back(s);
		scenes_queued++;
	endtask

	task automatic queue_random(input int n);
		@(posedge clk);
		repeat (n)
			queue_scene(random_scene());
	endtask

	// Hold until every queued snapshot has been transferred and every decision checked
	task automatic wait_drained();
		do
			@(negedge clk);
		while (scenes_taken != scenes_queued || moves_due.size() != 0);
	endtask

	// Sender: advance to the next snapshot only after a transfer, idle at random otherwise
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (scene_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_item  <= scene_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a long hold-off when asked for, random stalls otherwise
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (holdoff_left > 0) begin
			out_stall    <= 1'b1;
			holdoff_left <= holdoff_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Track registers and phase, predict on each input transfer, check each output transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_l       <= '0;
			box_r       <= '0;
			box_t       <= '0;
			box_b       <= '0;
			box_margin  <= '0;
			own_sel     <= OWN_CAR_RESET;
			phase_track <= PHASE_IDLE;
			in_taken    <= 1'b0;
		end else begin
			cycle_count++;
			if (cfg_we) begin
				case (cfg_index)
					REG_BOX_LEFT:   box_l      <= coord_t'(cfg_data);
					REG_BOX_RIGHT:  box_r      <= coord_t'(cfg_data);
					REG_BOX_TOP:    box_t      <= coord_t'(cfg_data);
					REG_BOX_BOTTOM: box_b      <= coord_t'(cfg_data);
					REG_MARGIN:     box_margin <= cfg_data[MARGIN_W-1:0];
					REG_OWN_CAR:    own_sel    <= cfg_data[OWN_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (moves_due.size() == 0) begin
					report_mismatch("decision with no snapshot outstanding",
						out_item.drive_command, -1);
				end else begin
					move_due = moves_due.pop_front();
					if (out_item.drive_command !== move_due.drive_command)
						report_mismatch("drive_command", out_item.drive_command,
							move_due.drive_command);
					if (out_item.phase_now !== move_due.phase_now)
						report_mismatch("phase_now", out_item.phase_now, move_due.phase_now);
				end
			end
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				move_due = crossing_decision(in_item, phase_track);
				moves_due.push_back(move_due);
				phase_track <= move_due.phase_now;
				scenes_taken++;
			end
			if (cycle_count == CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		in_item_t far_scene;
		in_item_t s;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed walk: box +-100, margin 20, own car 3
		set_crossing(-100, 100, 100, -100, 20, 3);
		set_pace(0, 0);
		far_scene = '0;
		for (int k = 1; k <= NUM_CARS; k++)
			far_scene = put_car(far_scene, k, 1000, 1000);
		@(posedge clk);
		queue_scene({12{16'h7FFF}});                // every field at its top: nobody near
		queue_scene({12{16'h8000}});                // every field at its bottom
		queue_scene({12{16'hFFFF}});                // all at (-1,-1): own car enters, stop
		queue_scene({12{16'hFFFF}});                // others in the core: keep waiting
		queue_scene(far_scene);                     // road clear: go
		queue_scene(put_car(far_scene, 3, 110, 0)); // own car in the margin ring: keep crossing
		queue_scene(put_car(far_scene, 3, 120, 0)); // exactly on the widened edge: back to idle
		s = put_car(far_scene, 3, 119, 0);
		queue_scene(s);                             // just inside the widened box: wait
		queue_scene(put_car(s, 1, -115, 0));        // lower car in the ring blocks
		queue_scene(put_car(s, 5, -115, 0));        // higher car in the ring does not
		queue_scene(put_car(far_scene, 3, 0, 0));   // crossing on
		queue_scene(far_scene);                     // left the box: idle
		s = put_car(far_scene, 3, 100, 0);
		queue_scene(s);                             // core edge still inside the widened box
		queue_scene(put_car(put_car(s, 4, 100, 50), 2, -120, 0)); // edges are not inside
		queue_scene(far_scene);
		queue_scene('0);                            // all at the centre: wait
		queue_scene('0);                            // others in the core: stop
		queue_scene(put_car(put_car(far_scene, 3, 0, 0), 6, 0, 99));
		queue_scene(put_car(far_scene, 3, 0, 0));   // clear: go
		queue_scene(far_scene);
		wait_drained();

		// Ordinary box, first car owns, no idling on either side
		set_crossing(-500, 500, 400, -300, 64, 1);
		set_pace(0, 0);
		queue_random(300);
		wait_drained();

		// Widest margin, last car owns, sender mostly idle
		set_crossing(-2000, 1500, 3000, -2500, 16383, 6);
		set_pace(77, 0);
		queue_random(300);
		wait_drained();

		// Box over the whole coordinate range, no margin, own car 0 stands for car 1
		set_crossing(-32768, 32767, 32767, -32768, 0, 0);
		set_pace(0, 77);
		queue_random(300);
		wait_drained();

		// Small offset box, own car 7 stands for the last car, both sides idling
		set_crossing(100, 140, -50, -90, 300, 7);
		set_pace(32, 32);
		queue_random(300);
		wait_drained();

		// Inverted box: hold the receiver off while the sender floods, so the block backs up
		set_crossing(200, -200, -10, 10, 5, 4);
		set_pace(0, 0);
		holdoff_left = 400;
		queue_random(250);
		// pause the sender until every decision has come back, then carry on
		wait_drained();
		set_pace(77, 77);
		queue_random(250);
		wait_drained();

		// Empty core with a wide margin around it
		set_crossing(0, 0, 0, 0, 1000, 2);
		set_pace(0, 0);
		queue_random(200);
		wait_drained();

		repeat (5) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
